>>> sv/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; included by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define CRRS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Same check, but also evaluated during reset.
`define CRRS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

>>> sv/crrs_pkg.sv
// Types and constants of the credit round robin scheduler.
// Depends on nothing; imported by every module of the block.
package crrs_pkg;
   localparam int TaskW  = 4;
   localparam int PrioW  = 7;
   localparam int TimeW  = 32;

   typedef enum logic [2:0] {
      CMD_ADMIT = 3'd0, CMD_YIELD = 3'd1, CMD_SLEEP = 3'd2, CMD_EXIT = 3'd3,
      CMD_BLOCK = 3'd4, CMD_SETPRIO = 3'd5, CMD_TICK = 3'd6, CMD_NOP = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_PRIO_ZERO = 2'd1, ST_FULL = 2'd2, ST_RSVD = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]       cmd;
      logic [TaskW-1:0] task_id;
      logic [PrioW-1:0] prio_value;
      logic [15:0]      sleep_ticks;
   } req_type;

   typedef struct packed {
      logic [TaskW-1:0] running_task;
      logic             running_valid;
      logic [PrioW-1:0] running_prio;
      logic [TimeW-1:0] time_now;
      logic [1:0]       status;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE, S_INSERT, S_WAKE, S_PICK, S_CHECK, S_DONE
   } state_type;

   // Sleep cell control: shift pattern for the sleep chain.
   typedef struct packed {
      logic             ins;     // insert new entry at sorted place
      logic             pop;     // remove front entry (shift toward front)
      logic [TaskW-1:0] new_id;
      logic [TimeW-1:0] new_dl;
   } sleep_ctl_type;
endpackage

>>> sv/credit_round_robin_scheduler.sv
// Credit round robin task scheduler. One request word gives one response word. A reschedule
// first wakes sleepers, one per cycle from the front of the sleep chain, and then, unless the
// ready queue ends empty, rotates the ready queue (a credit lookup and a decision per task
// tried) until a task with credit is found. Every command passes through the insert state
// before any wake phase. Ready queue and sleep list are shifting chains of cells; task
// priorities are a register file and level credits a small memory with a written flag per
// level, so a level not written since reset reads zero and one not written since the last
// refill reads 2*level. A response waits in an output register; the next request is taken
// once the response has moved into that register.
module credit_round_robin_scheduler #(
   parameter int MAX_TASKS   = 16,
   parameter int PRIO_LEVELS = 65
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  crrs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output crrs_pkg::rsp_type rsp_data
);
   import crrs_pkg::*;

   localparam int IdxW = $clog2(MAX_TASKS);
   localparam int CntW = $clog2(MAX_TASKS + 1);
   localparam int LvW  = $clog2(PRIO_LEVELS);
   localparam logic [PrioW-1:0] MaxPrio = PrioW'(PRIO_LEVELS - 1);

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   rsp_type   rsp_ff, rsp_in;
   logic      rsp_valid_ff, rsp_valid_in;

   logic [CntW-1:0]  rcount_ff, rcount_in;
   logic [CntW-1:0]  scount_ff, scount_in;
   logic [TaskW-1:0] run_task_ff, run_task_in;
   logic             run_valid_ff, run_valid_in;
   logic [TimeW-1:0] tick_ff, tick_in;
   logic [1:0]       status_ff, status_in;
   logic [TaskW-1:0] first_ff, first_in;
   logic [TaskW-1:0] cur_ff, cur_in;
   logic             rotated_ff, rotated_in;
   logic [7:0]       credit_rd_ff;
   logic [LvW-1:0]   lv_ff;

   logic [PrioW-1:0] prio_ff [MAX_TASKS];
   logic [7:0]       credit_ff [PRIO_LEVELS];
   logic [PRIO_LEVELS-1:0] credit_vld_ff;
   logic             credit_fill_ff;
   logic             refill;
   logic             credit_dec;
   logic             prio_we;
   logic [TaskW-1:0] prio_wa;
   logic [PrioW-1:0] prio_wd;

   // ready chain control
   logic             r_pop, r_load;
   logic [CntW-1:0]  r_load_pos;
   logic [TaskW-1:0] r_load_id;
   logic [TaskW-1:0] r_id [MAX_TASKS];

   // sleep chain control
   sleep_ctl_type    s_ctl;
   logic             s_used [MAX_TASKS];
   logic             s_gb   [MAX_TASKS];
   logic [TaskW-1:0] s_id   [MAX_TASKS];
   logic [TimeW-1:0] s_dl   [MAX_TASKS];

   logic [PrioW-1:0] pv_clamp;
   logic [TaskW-1:0] tid;
   logic [TimeW:0]   dl_sum;

   assign tid      = TaskW'(IdxW'(req_ff.task_id));
   assign pv_clamp = (req_ff.prio_value > MaxPrio) ? MaxPrio : req_ff.prio_value;
   assign dl_sum   = {1'b0, tick_ff} + {{(TimeW - 16 + 1){1'b0}}, req_ff.sleep_ticks};

   // ready queue cells
   for (genvar g = 0; g < MAX_TASKS; g++) begin : g_ring
      logic [TaskW-1:0] nxt;
      logic             ld;
      if (g == MAX_TASKS - 1) begin : g_last
         assign nxt = r_id[g];
      end else begin : g_mid
         assign nxt = r_id[g+1];
      end
      // with a pop the tail position moves one place toward the head
      assign ld = r_load && (CntW'(g) == (r_pop ? r_load_pos - 1'b1 : r_load_pos));
      crrs_ring_cell u_cell (
         .clock(clock), .pop(r_pop), .load(ld), .load_id(r_load_id),
         .next_id(nxt), .id(r_id[g])
      );
   end

   // sleep chain cells
   for (genvar g = 0; g < MAX_TASKS; g++) begin : g_sleep
      logic pu, pg, nu;
      logic [TaskW-1:0] pi, ni;
      logic [TimeW-1:0] pd, nd;
      if (g == 0) begin : g_first
         assign pu = 1'b0; assign pg = 1'b1; assign pi = '0; assign pd = '0;
      end else begin : g_p
         assign pu = s_used[g-1]; assign pg = s_gb[g-1];
         assign pi = s_id[g-1];   assign pd = s_dl[g-1];
      end
      if (g == MAX_TASKS - 1) begin : g_last
         assign nu = 1'b0; assign ni = '0; assign nd = '0;
      end else begin : g_n
         assign nu = s_used[g+1]; assign ni = s_id[g+1]; assign nd = s_dl[g+1];
      end
      crrs_sleep_cell u_cell (
         .clock(clock), .reset(reset), .ctl(s_ctl),
         .prev_used(pu), .prev_goes_before(pg), .prev_id(pi), .prev_dl(pd),
         .next_used(nu), .next_id(ni), .next_dl(nd),
         .used(s_used[g]), .goes_before(s_gb[g]), .id(s_id[g]), .dl(s_dl[g])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_valid && req_ready) state_in = S_INSERT;
         S_INSERT: begin
            case (req_ff.cmd)
               CMD_ADMIT:   state_in = (req_ff.prio_value == '0 || run_valid_ff) ?
                                       S_DONE : S_WAKE;
               CMD_YIELD, CMD_SLEEP, CMD_EXIT, CMD_BLOCK: state_in = S_WAKE;
               CMD_TICK:    state_in = run_valid_ff ? S_DONE : S_WAKE;
               default:     state_in = S_DONE;
            endcase
         end
         S_WAKE: begin
            if (!(scount_ff != '0 && s_dl[0] <= tick_ff && rcount_ff < CntW'(MAX_TASKS)))
               state_in = (rcount_ff == '0) ? S_DONE : S_PICK;
         end
         S_PICK:  state_in = S_CHECK;
         S_CHECK: state_in = (!refill && credit_rd_ff != 8'd0) ? S_DONE : S_PICK;
         S_DONE:  if (rsp_ready || !rsp_valid_ff) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign refill = 1'b0;

   // datapath and outputs
   always_comb begin
      req_in       = req_ff;
      rcount_in    = rcount_ff;
      scount_in    = scount_ff;
      run_task_in  = run_task_ff;
      run_valid_in = run_valid_ff;
      tick_in      = tick_ff;
      status_in    = status_ff;
      first_in     = first_ff;
      cur_in       = cur_ff;
      rotated_in   = rotated_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      r_pop        = 1'b0;
      r_load       = 1'b0;
      r_load_pos   = rcount_ff;
      r_load_id    = tid;
      s_ctl        = '{ins: 1'b0, pop: 1'b0, new_id: run_task_ff,
                       new_dl: dl_sum[TimeW] ? '1 : dl_sum[TimeW-1:0]};
      prio_we      = 1'b0;
      prio_wa      = tid;
      prio_wd      = pv_clamp;
      credit_dec   = 1'b0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               req_in    = req_data;
               status_in = ST_OK;
            end
         end
         S_INSERT: begin
            case (req_ff.cmd)
               CMD_ADMIT: begin
                  if (req_ff.prio_value == '0) status_in = ST_PRIO_ZERO;
                  else begin
                     prio_we = 1'b1;
                     if (rcount_ff < CntW'(MAX_TASKS)) begin
                        r_load = 1'b1; rcount_in = rcount_ff + 1'b1;
                     end else status_in = ST_FULL;
                  end
               end
               CMD_YIELD: begin
                  if (run_valid_ff) begin
                     if (rcount_ff < CntW'(MAX_TASKS)) begin
                        r_load = 1'b1; r_load_id = run_task_ff;
                        rcount_in = rcount_ff + 1'b1;
                     end else status_in = ST_FULL;
                  end
                  run_valid_in = 1'b0;
               end
               CMD_SLEEP: begin
                  if (run_valid_ff) begin
                     if (scount_ff < CntW'(MAX_TASKS)) begin
                        s_ctl.ins = 1'b1; scount_in = scount_ff + 1'b1;
                     end else status_in = ST_FULL;
                  end
                  run_valid_in = 1'b0;
               end
               CMD_EXIT, CMD_BLOCK: run_valid_in = 1'b0;
               CMD_SETPRIO: begin
                  if (req_ff.prio_value == '0) status_in = ST_PRIO_ZERO;
                  else if (run_valid_ff) begin
                     prio_we = 1'b1; prio_wa = run_task_ff;
                  end
               end
               CMD_TICK: if (tick_ff != '1) tick_in = tick_ff + 1'b1;
               default: ;
            endcase
         end
         S_WAKE: begin
            if (scount_ff != '0 && s_dl[0] <= tick_ff && rcount_ff < CntW'(MAX_TASKS)) begin
               r_load = 1'b1; r_load_id = s_id[0];
               rcount_in = rcount_ff + 1'b1;
               s_ctl.pop = 1'b1; scount_in = scount_ff - 1'b1;
            end else if (rcount_ff == '0) run_valid_in = 1'b0;
            else begin
               // take the first head
               first_in   = r_id[0];
               cur_in     = r_id[0];
               rotated_in = 1'b0;
               r_pop      = 1'b1;
               rcount_in  = rcount_ff - 1'b1;
            end
         end
         S_PICK: ;
         S_CHECK: begin
            if (credit_rd_ff != 8'd0) begin
               credit_dec   = 1'b1;
               run_task_in  = cur_ff;
               run_valid_in = 1'b1;
            end else begin
               // rotate: push current to tail, pop next head
               r_load     = 1'b1;
               r_load_id  = cur_ff;
               r_pop      = 1'b1;
               cur_in     = (rcount_ff == '0) ? cur_ff : r_id[0];
               rotated_in = 1'b1;
            end
         end
         S_DONE: begin
            if (rsp_ready || !rsp_valid_ff) begin
               rsp_valid_in           = 1'b1;
               rsp_in.running_valid   = run_valid_ff;
               rsp_in.running_task    = run_valid_ff ? run_task_ff : '0;
               rsp_in.running_prio    = run_valid_ff ? prio_ff[IdxW'(run_task_ff)] : '0;
               rsp_in.time_now        = tick_ff;
               rsp_in.status          = status_ff;
            end
         end
         default: ;
      endcase
   end

   // credit read for the current task; refill when the rotation returns to first
   logic [LvW-1:0] lv_cur;
   logic           do_refill;
   logic [7:0]     credit_dflt;
   assign lv_cur      = LvW'(prio_ff[IdxW'(cur_ff)] > MaxPrio ? MaxPrio :
                             prio_ff[IdxW'(cur_ff)]);
   assign do_refill   = (state_ff == S_PICK) && rotated_ff && (cur_ff == first_ff);
   // value of a level not written since reset or since the last refill
   assign credit_dflt = credit_fill_ff ? 8'(2 * lv_cur) : 8'd0;

   // written flags: a refill clears them all
   always_ff @(posedge clock) begin
      if (reset) begin
         credit_vld_ff  <= '0;
         credit_fill_ff <= 1'b0;
      end else if (do_refill) begin
         credit_vld_ff  <= '0;
         credit_fill_ff <= 1'b1;
      end else if (credit_dec) begin
         credit_vld_ff[lv_ff] <= 1'b1;
      end
   end

   // credit memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (credit_dec) credit_ff[lv_ff] <= credit_rd_ff - 8'd1;
      if (state_ff == S_PICK) begin
         lv_ff        <= lv_cur;
         credit_rd_ff <= do_refill ? ((lv_cur == '0) ? 8'd0 : 8'(2 * lv_cur))
                       : (credit_vld_ff[lv_cur] ? credit_ff[lv_cur] : credit_dflt);
      end
   end

   // task priorities
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_TASKS; i++) prio_ff[i] <= PrioW'(1);
      end else if (prio_we) begin
         prio_ff[IdxW'(prio_wa)] <= prio_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         rcount_ff    <= '0;
         scount_ff    <= '0;
         run_task_ff  <= '0;
         run_valid_ff <= 1'b0;
         tick_ff      <= '0;
         status_ff    <= ST_OK;
         rotated_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rcount_ff    <= rcount_in;
         scount_ff    <= scount_in;
         run_task_ff  <= run_task_in;
         run_valid_ff <= run_valid_in;
         tick_ff      <= tick_in;
         status_ff    <= status_in;
         rotated_ff   <= rotated_in;
      end
      req_ff   <= req_in;
      rsp_ff   <= rsp_in;
      first_ff <= first_in;
      cur_ff   <= cur_in;
   end

   assign req_ready = (state_ff == S_IDLE) && !refill;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

>>> sv/crrs_sleep_cell.sv
// One cell of the sorted sleep chain: one id, deadline and occupied bit.
// Depends on crrs_pkg; instantiated by credit_round_robin_scheduler.
module crrs_sleep_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  crrs_pkg::sleep_ctl_type   ctl,
   // neighbor toward the front (lower index)
   input  logic                      prev_used,
   input  logic                      prev_goes_before,
   input  logic [crrs_pkg::TaskW-1:0] prev_id,
   input  logic [crrs_pkg::TimeW-1:0] prev_dl,
   // neighbor toward the back
   input  logic                      next_used,
   input  logic [crrs_pkg::TaskW-1:0] next_id,
   input  logic [crrs_pkg::TimeW-1:0] next_dl,
   output logic                      used,
   output logic                      goes_before,
   output logic [crrs_pkg::TaskW-1:0] id,
   output logic [crrs_pkg::TimeW-1:0] dl
);
   import crrs_pkg::*;

   logic             used_ff, used_in;
   logic [TaskW-1:0] id_ff, id_in;
   logic [TimeW-1:0] dl_ff, dl_in;

   // entry stays ahead of a new sleeper when its deadline is not later
   assign goes_before = used_ff && (dl_ff <= ctl.new_dl);

   always_comb begin
      used_in = used_ff;
      id_in   = id_ff;
      dl_in   = dl_ff;
      if (ctl.pop) begin
         used_in = next_used;
         id_in   = next_id;
         dl_in   = next_dl;
      end else if (ctl.ins) begin
         if (!goes_before && prev_goes_before) begin
            used_in = 1'b1;
            id_in   = ctl.new_id;
            dl_in   = ctl.new_dl;
         end else if (!goes_before) begin
            used_in = prev_used;
            id_in   = prev_id;
            dl_in   = prev_dl;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) used_ff <= 1'b0;
      else       used_ff <= used_in;
      id_ff <= id_in;
      dl_ff <= dl_in;
   end

   assign used = used_ff;
   assign id   = id_ff;
   assign dl   = dl_ff;
endmodule

>>> sv/crrs_ring_cell.sv
// One cell of the ready queue chain; the chain shifts toward the head.
// Depends on crrs_pkg; instantiated by credit_round_robin_scheduler.
module crrs_ring_cell (
   input  logic                       clock,
   input  logic                       pop,
   input  logic                       load,
   input  logic [crrs_pkg::TaskW-1:0] load_id,
   input  logic [crrs_pkg::TaskW-1:0] next_id,
   output logic [crrs_pkg::TaskW-1:0] id
);
   import crrs_pkg::*;

   logic [TaskW-1:0] id_ff, id_in;

   // a pop shifts every cell one place toward the head; load writes the tail
   always_comb begin
      id_in = id_ff;
      if (pop)  id_in = next_id;
      if (load) id_in = load_id;
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in;
   end

   assign id = id_ff;
endmodule

>>> sv/crrs_checker.sv
// Port-level checks for the credit round robin scheduler, bound to the top level.
// Depends on crrs_pkg and assert_macros.svh.
`include "assert_macros.svh"
module crrs_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input crrs_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input crrs_pkg::rsp_type rsp_data
);
   import crrs_pkg::*;

   `CRRS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "response changed while stalled")
   `CRRS_ASSERT(a_idle_zero, clock, reset, rsp_valid && !rsp_data.running_valid |-> rsp_data.running_task == '0 && rsp_data.running_prio == '0, "idle response not zero")
   `CRRS_ASSERT(a_status_code, clock, reset, rsp_valid |-> rsp_data.status != ST_RSVD, "reserved status")
   `CRRS_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid, "response after reset")
endmodule

bind credit_round_robin_scheduler crrs_checker u_crrs_checker (.*);
